[sv/hsv_gamma_saturation_correct_unit_assert.svh]
// Assertion macros for the HSV gamma and saturation correction block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HSV_GAMMA_SATURATION_CORRECT_UNIT_ASSERT_SVH
`define HSV_GAMMA_SATURATION_CORRECT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define HGSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define HGSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define HGSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HGSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/hgsc_pkg.sv]
// Shared types and constants of the HSV gamma and saturation correction block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package hgsc_pkg;

  // Value curve geometry.
  localparam int CURVE_ENTRIES = 256;
  localparam int CURVE_AW      = 8;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MASTER_GAIN    = 3'd2;
  localparam logic [2:0] REG_SHADOW_GAIN    = 3'd3;
  localparam logic [2:0] REG_MIDTONE_GAIN   = 3'd4;
  localparam logic [2:0] REG_HIGHLIGHT_GAIN = 3'd5;

  // Request commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // Hue sectors, starting at red and going round through yellow, green and so on.
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  // Configuration register values.
  typedef struct packed {
    logic [15:0] low_threshold;
    logic [15:0] high_threshold;
    logic [15:0] master_gain;
    logic [15:0] shadow_gain;
    logic [15:0] midtone_gain;
    logic [15:0] highlight_gain;
  } cfg_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  addr;    // curve entry: the maximum byte, or the load index
    logic [15:0] wval;    // curve value for a load
    logic [7:0]  delta;
    logic [7:0]  num;
    logic [2:0]  sector;
  } q_item_t;

endpackage

[sv/hgsc_front.sv]
// Front of the correction block: classifies each request into curve address,
// chroma, hue sector and hue numerator. Depends on hgsc_pkg.
module hgsc_front
  import hgsc_pkg::*;
(
  input  logic        cmd,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_value,
  output q_item_t     item
);

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] delta;
  logic [7:0] num_raw;
  logic [2:0] sec_raw;
  logic [2:0] sec_inc;

  // Largest and smallest channel.
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
  end

  // Hue sector and numerator of the fraction.
  always_comb begin
    if (red >= green && red >= blue) begin
      if (green >= blue) begin
        sec_raw = SEC_RY;
        num_raw = green - blue;
      end else begin
        sec_raw = SEC_MR;
        num_raw = delta - (blue - green);
      end
    end else if (green >= blue) begin
      if (blue >= red) begin
        sec_raw = SEC_GC;
        num_raw = blue - red;
      end else begin
        sec_raw = SEC_YG;
        num_raw = delta - (red - blue);
      end
    end else begin
      if (red >= green) begin
        sec_raw = SEC_BM;
        num_raw = red - green;
      end else begin
        sec_raw = SEC_CB;
        num_raw = delta - (green - red);
      end
    end
  end

  // Following sector, used when the numerator reaches the full chroma.
  always_comb begin
    case (sec_raw)
      SEC_RY:  sec_inc = SEC_YG;
      SEC_YG:  sec_inc = SEC_GC;
      SEC_GC:  sec_inc = SEC_CB;
      SEC_CB:  sec_inc = SEC_BM;
      SEC_BM:  sec_inc = SEC_MR;
      default: sec_inc = SEC_RY;
    endcase
  end

  // Assemble the queue entry.
  always_comb begin
    item.cmd   = cmd;
    item.addr  = (cmd == CMD_LOAD) ? entry_index : mx;
    item.wval  = entry_value;
    item.delta = delta;
    if (num_raw >= delta) begin
      item.sector = sec_inc;
      item.num    = 8'd0;
    end else begin
      item.sector = sec_raw;
      item.num    = num_raw;
    end
  end

endmodule

[sv/hgsc_queue.sv]
// Short queue that decouples the front from the back of the correction block.
// Depends on hgsc_pkg for the entry type and depth.
module hgsc_queue
  import hgsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head
);

  q_item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

[sv/hgsc_back.sv]
// Back of the correction block: curve memory, pipelined dividers for
// saturation and hue fraction, gain and channel multipliers, output register.
// Depends on hgsc_pkg and the assertion macro header.
`include "hsv_gamma_saturation_correct_unit_assert.svh"
module hgsc_back
  import hgsc_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  q_item_t    head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  localparam int F = FRACTION_BITS;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic en;

  // Curve memory.
  logic [15:0] curve_mem [CURVE_ENTRIES];

  // Divider pipeline, stage 0 is the memory read stage.
  logic         dv_r  [0:F];
  logic         dgy_r [0:F];
  logic [2:0]   dsec_r[0:F];
  logic [15:0]  dvc_r [0:F];
  logic [7:0]   dmx_r [0:F];
  logic [7:0]   ddl_r [0:F];
  logic [7:0]   drs_r [0:F];
  logic [7:0]   drf_r [0:F];
  logic [F-1:0] dqs_r [0:F];
  logic [F-1:0] dqf_r [0:F];

  // Gain stage.
  logic         a_v_r;
  logic         a_gy_r;
  logic [2:0]   a_sec_r;
  logic [15:0]  a_vc_r;
  logic [F:0]   a_s_r;
  logic [F-1:0] a_f_r;
  logic [31:0]  a_gain_r;
  logic [15:0]  region_gain;

  // Scaled saturation stage.
  logic          b_v_r;
  logic          b_gy_r;
  logic [2:0]    b_sec_r;
  logic [15:0]   b_vc_r;
  logic [F:0]    b_s_r;
  logic [F-1:0]  b_f_r;
  logic [F+32:0] s_prod;
  logic [F+8:0]  s_shift;
  logic [F:0]    s_nxt;

  // Channel factor stage.
  logic          c_v_r;
  logic          c_gy_r;
  logic [2:0]    c_sec_r;
  logic [15:0]   c_vc_r;
  logic [F:0]    c_fw_r;
  logic [F:0]    c_fq_r;
  logic [F:0]    c_ft_r;
  logic [2*F:0]  sf_prod;
  logic [2*F+1:0] st_prod;
  logic [F:0]    one_minus_f;

  // Output stage.
  logic          out_valid_r;
  logic [7:0]    red_r;
  logic [7:0]    green_r;
  logic [7:0]    blue_r;
  logic [F:0]    ch0;
  logic [F:0]    ch1;
  logic [F:0]    ch2;
  logic [F+16:0] p0;
  logic [F+16:0] p1;
  logic [F+16:0] p2;

  // The whole back advances together whenever the output can move.
  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_valid;

  assign out_valid = out_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  // Curve loads and reads happen in request order at the pop.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.cmd == CMD_LOAD) begin
        curve_mem[head.addr] <= head.wval;
      end else begin
        dvc_r[0] <= curve_mem[head.addr];
      end
    end
  end

  // Stage 0 payload: divider start values.
  always_ff @(posedge clk) begin
    if (en) begin
      dgy_r[0]  <= (head.delta == 8'd0);
      dsec_r[0] <= head.sector;
      dmx_r[0]  <= head.addr;
      ddl_r[0]  <= head.delta;
      drs_r[0]  <= head.delta;
      drf_r[0]  <= head.num;
      dqs_r[0]  <= '0;
      dqf_r[0]  <= '0;
    end
  end

  // One quotient bit of each division per stage.
  for (genvar k = 0; k < F; k++) begin : g_div
    logic [8:0] ts;
    logic [8:0] tf;
    logic [7:0] rs_nxt;
    logic [7:0] rf_nxt;
    logic       bs;
    logic       bf;

    always_comb begin
      ts = {drs_r[k], 1'b0};
      tf = {drf_r[k], 1'b0};
      bs = (ts >= {1'b0, dmx_r[k]});
      bf = (tf >= {1'b0, ddl_r[k]});
      rs_nxt = bs ? 8'(ts - {1'b0, dmx_r[k]}) : ts[7:0];
      rf_nxt = bf ? 8'(tf - {1'b0, ddl_r[k]}) : tf[7:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dgy_r[k+1]  <= dgy_r[k];
        dsec_r[k+1] <= dsec_r[k];
        dvc_r[k+1]  <= dvc_r[k];
        dmx_r[k+1]  <= dmx_r[k];
        ddl_r[k+1]  <= ddl_r[k];
        drs_r[k+1]  <= rs_nxt;
        drf_r[k+1]  <= rf_nxt;
        dqs_r[k+1]  <= {dqs_r[k][F-2:0], bs};
        dqf_r[k+1]  <= {dqf_r[k][F-2:0], bf};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end
  end

  // Region gain chosen from the corrected value.
  always_comb begin
    if ({dvc_r[F][15:8], 8'd0} < cfg.low_threshold) begin
      region_gain = cfg.shadow_gain;
    end else if ({dvc_r[F][15:8], 8'd0} > cfg.high_threshold) begin
      region_gain = cfg.highlight_gain;
    end else begin
      region_gain = cfg.midtone_gain;
    end
  end

  // When the smallest channel is zero the chroma equals the maximum and the
  // saturation is exactly one; the remainder then stays equal to the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      a_gy_r   <= dgy_r[F];
      a_sec_r  <= dsec_r[F];
      a_vc_r   <= dvc_r[F];
      a_s_r    <= (drs_r[F] == dmx_r[F]) ? ONE : {1'b0, dqs_r[F]};
      a_f_r    <= dqf_r[F];
      a_gain_r <= region_gain * cfg.master_gain;
    end
  end

  // Saturation times gain, saturated at one and kept above zero.
  always_comb begin
    s_prod  = a_s_r * a_gain_r;
    s_shift = s_prod[F+32:24];
    if (s_shift >= (F+9)'(ONE)) begin
      s_nxt = ONE;
    end else if (s_shift == '0) begin
      s_nxt = (F+1)'(1);
    end else begin
      s_nxt = s_shift[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_gy_r  <= a_gy_r;
      b_sec_r <= a_sec_r;
      b_vc_r  <= a_vc_r;
      b_s_r   <= s_nxt;
      b_f_r   <= a_f_r;
    end
  end

  // Channel factors from saturation and hue fraction.
  always_comb begin
    one_minus_f = ONE - {1'b0, b_f_r};
    sf_prod     = b_s_r * b_f_r;
    st_prod     = b_s_r * one_minus_f;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_gy_r  <= b_gy_r;
      c_sec_r <= b_sec_r;
      c_vc_r  <= b_vc_r;
      c_fw_r  <= ONE - b_s_r;
      c_fq_r  <= ONE - sf_prod[2*F:F];
      c_ft_r  <= ONE - st_prod[2*F:F];
    end
  end

  // Factor per channel by hue sector.
  always_comb begin
    case (c_sec_r)
      SEC_RY: begin
        ch0 = ONE;    ch1 = c_ft_r; ch2 = c_fw_r;
      end
      SEC_YG: begin
        ch0 = c_fq_r; ch1 = ONE;    ch2 = c_fw_r;
      end
      SEC_GC: begin
        ch0 = c_fw_r; ch1 = ONE;    ch2 = c_ft_r;
      end
      SEC_CB: begin
        ch0 = c_fw_r; ch1 = c_fq_r; ch2 = ONE;
      end
      SEC_BM: begin
        ch0 = c_ft_r; ch1 = c_fw_r; ch2 = ONE;
      end
      default: begin
        ch0 = ONE;    ch1 = c_fw_r; ch2 = c_fq_r;
      end
    endcase
    p0 = c_vc_r * ch0;
    p1 = c_vc_r * ch1;
    p2 = c_vc_r * ch2;
  end

  // Output register; gray pixels leave at the corrected value.
  always_ff @(posedge clk) begin
    if (en) begin
      if (c_gy_r) begin
        red_r   <= c_vc_r[15:8];
        green_r <= c_vc_r[15:8];
        blue_r  <= c_vc_r[15:8];
      end else begin
        red_r   <= p0[F+15:F+8];
        green_r <= p1[F+15:F+8];
        blue_r  <= p2[F+15:F+8];
      end
    end
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0]     <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r[0]     <= pop && (head.cmd == CMD_PIXEL);
      a_v_r       <= dv_r[F];
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      out_valid_r <= c_v_r;
    end
  end

  // A curve load never turns into a result.
  `HGSC_ASSERT_NXT(a_load_no_result, clk, rst_n, pop && (head.cmd == CMD_LOAD), !dv_r[0])
  // While the output is stalled the pipeline holds its contents.
  `HGSC_ASSERT_NXT(a_stall_holds, clk, rst_n, !en, $stable(c_v_r) && $stable(a_v_r))
  // Nothing leaves the queue while the output is stalled.
  `HGSC_ASSERT_IMP(a_no_pop_on_stall, clk, rst_n, out_valid_r && !out_ready, !pop)

endmodule

[sv/hsv_gamma_saturation_correct_unit.sv]
// HSV gamma and saturation correction of 8-bit RGB pixels.
// Requests enter on the in_ channel (valid/ready); in_cmd selects a pixel or a
// load of one value curve entry. Each pixel request yields one result on the
// out_ channel; a load yields none. Six 16-bit registers sit on the APB-style
// port at byte addresses 0 to 20 in steps of 4; the user must see that they
// are written only while idle, as the block does not enforce it. A pixel
// passes from acceptance to out_valid through the queue, whose pop also reads
// the curve memory, one divider stage per fraction bit, then gain, saturation
// scaling and factor stages and the output register. One request is accepted
// per cycle while out_ready stays high. When the receiver stalls, the back
// pipeline holds and a four-entry queue keeps taking requests until it fills,
// then in_ready falls. Reset empties the queue and pipeline and returns the
// registers to their defaults; the value curve holds nothing until loaded,
// and every entry must be loaded before the first pixel.
// Depends on hgsc_pkg, hgsc_front, hgsc_queue and hgsc_back.
module hsv_gamma_saturation_correct_unit
  import hgsc_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_entry_index,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_r;
  q_item_t  item;
  q_item_t  head;
  logic     q_full;
  logic     head_valid;
  logic     pop;
  logic     push;
  logic     wr_en;
  logic [2:0] reg_idx;

  assign pready   = 1'b1;
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold  <= 16'd16320;
      cfg_r.high_threshold <= 16'd48960;
      cfg_r.master_gain    <= 16'd4096;
      cfg_r.shadow_gain    <= 16'd4096;
      cfg_r.midtone_gain   <= 16'd4096;
      cfg_r.highlight_gain <= 16'd4096;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= pwdata[15:0];
        REG_HIGH_THRESHOLD: cfg_r.high_threshold <= pwdata[15:0];
        REG_MASTER_GAIN:    cfg_r.master_gain    <= pwdata[15:0];
        REG_SHADOW_GAIN:    cfg_r.shadow_gain    <= pwdata[15:0];
        REG_MIDTONE_GAIN:   cfg_r.midtone_gain   <= pwdata[15:0];
        REG_HIGHLIGHT_GAIN: cfg_r.highlight_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_LOW_THRESHOLD:  prdata = {16'd0, cfg_r.low_threshold};
      REG_HIGH_THRESHOLD: prdata = {16'd0, cfg_r.high_threshold};
      REG_MASTER_GAIN:    prdata = {16'd0, cfg_r.master_gain};
      REG_SHADOW_GAIN:    prdata = {16'd0, cfg_r.shadow_gain};
      REG_MIDTONE_GAIN:   prdata = {16'd0, cfg_r.midtone_gain};
      REG_HIGHLIGHT_GAIN: prdata = {16'd0, cfg_r.highlight_gain};
      default:            prdata = 32'd0;
    endcase
  end

  hgsc_front u_front (
    .cmd         (in_cmd),
    .red         (in_red_in),
    .green       (in_green_in),
    .blue        (in_blue_in),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .item        (item)
  );

  hgsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  hgsc_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (out_red_out),
    .green      (out_green_out),
    .blue       (out_blue_out)
  );

endmodule

[tb/hsv_gamma_saturation_correct_unit_checker.sv]
// Checker for the HSV gamma and saturation correction block: follows register
// writes and curve loads, predicts each pixel result and compares it.
// Depends on hgsc_pkg for register indexes, commands and hue sectors.
module hsv_gamma_saturation_correct_unit_checker
  import hgsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_entry_index,
  input  logic [15:0] in_entry_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_blue_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam logic [63:0] UNIT = 64'd1 << FB;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  cfg_t        regs;
  logic [15:0] curve [CURVE_ENTRIES];
  rgb_t        expected_pixels [$];

  // Output byte from the corrected value and one channel factor.
  function automatic logic [7:0] scale_byte(input logic [63:0] vc, input logic [63:0] factor);
    logic [63:0] prod;
    prod = (vc * factor) >> (FB + 8);
    return prod[7:0];
  endfunction

  // Predicted corrected pixel for the current registers and curve.
  function automatic rgb_t correct_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [63:0] mx, mn, delta, vc, y, gain, sat, num, frac, fw, fq, ft;
    logic [63:0] r64, g64, b64;
    logic [2:0]  sector;
    rgb_t        res;
    r64 = r;
    g64 = g;
    b64 = b;
    mx = r64; if (g64 > mx) mx = g64; if (b64 > mx) mx = b64;
    mn = r64; if (g64 < mn) mn = g64; if (b64 < mn) mn = b64;
    delta = mx - mn;
    vc = curve[mx[7:0]];
    // Gray pixels leave at the corrected value.
    if (delta == 0) begin
      res.red = vc[15:8];
      res.green = vc[15:8];
      res.blue = vc[15:8];
      return res;
    end
    sat = (delta << FB) / mx;
    // Region gain chosen from the corrected value.
    y = vc >> 8;
    if ((y << 8) < regs.low_threshold) gain = regs.shadow_gain;
    else if ((y << 8) > regs.high_threshold) gain = regs.highlight_gain;
    else gain = regs.midtone_gain;
    gain = gain * regs.master_gain;
    sat = (sat * gain) >> 24;
    if (sat >= UNIT) sat = UNIT;
    if (sat == 0) sat = 1;
    // Hue sector and fraction.
    if (r64 >= g64 && r64 >= b64) begin
      if (g64 >= b64) begin sector = SEC_RY; num = g64 - b64; end
      else begin sector = SEC_MR; num = delta - (b64 - g64); end
    end else if (g64 >= b64) begin
      if (b64 >= r64) begin sector = SEC_GC; num = b64 - r64; end
      else begin sector = SEC_YG; num = delta - (r64 - b64); end
    end else begin
      if (r64 >= g64) begin sector = SEC_BM; num = r64 - g64; end
      else begin sector = SEC_CB; num = delta - (g64 - r64); end
    end
    if (num >= delta) begin
      sector = (sector == SEC_MR) ? SEC_RY : sector + 3'd1;
      num = 0;
    end
    frac = (num << FB) / delta;
    fw = UNIT - sat;
    fq = UNIT - ((sat * frac) >> FB);
    ft = UNIT - ((sat * (UNIT - frac)) >> FB);
    case (sector)
      SEC_RY: begin
        res.red = scale_byte(vc, UNIT); res.green = scale_byte(vc, ft);
        res.blue = scale_byte(vc, fw);
      end
      SEC_YG: begin
        res.red = scale_byte(vc, fq); res.green = scale_byte(vc, UNIT);
        res.blue = scale_byte(vc, fw);
      end
      SEC_GC: begin
        res.red = scale_byte(vc, fw); res.green = scale_byte(vc, UNIT);
        res.blue = scale_byte(vc, ft);
      end
      SEC_CB: begin
        res.red = scale_byte(vc, fw); res.green = scale_byte(vc, fq);
        res.blue = scale_byte(vc, UNIT);
      end
      SEC_BM: begin
        res.red = scale_byte(vc, ft); res.green = scale_byte(vc, fw);
        res.blue = scale_byte(vc, UNIT);
      end
      default: begin
        res.red = scale_byte(vc, UNIT); res.green = scale_byte(vc, fw);
        res.blue = scale_byte(vc, fq);
      end
    endcase
    return res;
  endfunction

  // Follow register writes, requests and results at each rising edge.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      regs.low_threshold  <= 16'd16320;
      regs.high_threshold <= 16'd48960;
      regs.master_gain    <= 16'd4096;
      regs.shadow_gain    <= 16'd4096;
      regs.midtone_gain   <= 16'd4096;
      regs.highlight_gain <= 16'd4096;
      expected_pixels.delete();
      pending <= 0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LOW_THRESHOLD:  regs.low_threshold  <= pwdata[15:0];
          REG_HIGH_THRESHOLD: regs.high_threshold <= pwdata[15:0];
          REG_MASTER_GAIN:    regs.master_gain    <= pwdata[15:0];
          REG_SHADOW_GAIN:    regs.shadow_gain    <= pwdata[15:0];
          REG_MIDTONE_GAIN:   regs.midtone_gain   <= pwdata[15:0];
          REG_HIGHLIGHT_GAIN: regs.highlight_gain <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_LOAD) curve[in_entry_index] = in_entry_value;
        else expected_pixels.push_back(correct_pixel(in_red_in, in_green_in, in_blue_in));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with none expected: actual %h %h %h", $realtime,
                   out_red_out, out_green_out, out_blue_out);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== {out_red_out, out_green_out, out_blue_out}) begin
            $display("%0t: pixel mismatch: expected r %h g %h b %h, actual r %h g %h b %h",
                     $realtime, want.red, want.green, want.blue,
                     out_red_out, out_green_out, out_blue_out);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

[tb/hsv_gamma_saturation_correct_unit_test.sv]
// Testbench top for the HSV gamma and saturation correction block: makes the
// stimulus, register settings and back-pressure, and gives the verdict.
// Depends on hgsc_pkg, the block and hsv_gamma_saturation_correct_unit_checker.
module hsv_gamma_saturation_correct_unit_test;
  import hgsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 30;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_cmd;
  logic [7:0]  in_red_in, in_green_in, in_blue_in, in_entry_index;
  logic [15:0] in_entry_value;
  logic        out_valid, out_ready;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        taken;
  logic        hold_off;
  int          mismatches, pending;
  int          burst_left;

  hsv_gamma_saturation_correct_unit dut (.*);

  hsv_gamma_saturation_correct_unit_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remember whether the request on offer was taken at this edge.
  always @(posedge clk) taken <= in_valid && in_ready;

  // Receiver: random stalls, quiet stretches and one long hold-off on request.
  initial begin
    int cnt;
    bit held;
    out_ready = 1'b0;
    cnt = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cnt++;
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
      end else if ((cnt / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // One register write: setup phase then access phase.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] mg, input logic [15:0] sg,
                           input logic [15:0] mdg, input logic [15:0] hg);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_MASTER_GAIN, mg);
    write_reg(REG_SHADOW_GAIN, sg);
    write_reg(REG_MIDTONE_GAIN, mdg);
    write_reg(REG_HIGHLIGHT_GAIN, hg);
  endtask

  // Offer one request in bursts; valid stays high across back-to-back requests.
  task automatic offer(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                       input logic [7:0] b, input logic [7:0] idx, input logic [15:0] val);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    in_entry_index <= idx;
    in_entry_value <= val;
    do @(negedge clk); while (!taken);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    offer(CMD_PIXEL, r, g, b, 8'($urandom), 16'($urandom));
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [15:0] val);
    offer(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), idx, val);
  endtask

  // Let every result drain and the pipeline empty before touching registers.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Random pixel: mostly colourful, some gray, some nearly gray.
  task automatic random_pixel;
    logic [7:0] r, g, b;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 9))
      0: begin g = r; b = r; end
      1: begin g = 8'(r + $urandom_range(0, 2)); b = 8'(r - $urandom_range(0, 2)); end
      2: g = r;
      default: ;
    endcase
    pixel(r, g, b);
  endtask

  initial begin
    #5ms;
    $display("hsv_gamma_saturation_correct_unit_test failed");
    $finish;
  end

  initial begin
    logic [15:0] lo, hi;
    rst_n = 1'b0;
    in_valid = 1'b0; in_cmd = CMD_PIXEL;
    in_red_in = '0; in_green_in = '0; in_blue_in = '0;
    in_entry_index = '0; in_entry_value = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_off = 1'b0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every curve entry is loaded before the first pixel.
    for (int i = 0; i < CURVE_ENTRIES; i++) load_entry(i[7:0], 16'($urandom_range(0, 65535)));
    load_entry(8'd255, 16'hFFFF);
    load_entry(8'd0, 16'd0);
    load_entry(8'd128, 16'd65280);

    // Directed pixels at default settings: gray, primaries, ties and extremes.
    pixel(8'd0, 8'd0, 8'd0);
    pixel(8'd255, 8'd255, 8'd255);
    pixel(8'd255, 8'd0, 8'd0);
    pixel(8'd255, 8'd255, 8'd0);
    pixel(8'd0, 8'd255, 8'd0);
    pixel(8'd0, 8'd255, 8'd255);
    pixel(8'd0, 8'd0, 8'd255);
    pixel(8'd255, 8'd0, 8'd255);
    pixel(8'd200, 8'd100, 8'd50);
    pixel(8'd100, 8'd200, 8'd50);
    pixel(8'd50, 8'd100, 8'd200);
    pixel(8'd200, 8'd50, 8'd100);
    pixel(8'd50, 8'd200, 8'd100);
    pixel(8'd100, 8'd50, 8'd200);
    pixel(8'd128, 8'd127, 8'd127);
    pixel(8'd1, 8'd0, 8'd0);
    drain();

    // Gains set to zero on coloured pixels: the scaled saturation is held at its lowest value above zero.
    write_all(16'd0, 16'd65280, 16'd0, 16'd0, 16'd0, 16'd0);
    pixel(8'd255, 8'd1, 8'd0);
    pixel(8'd128, 8'd0, 8'd200);
    pixel(8'd254, 8'd255, 8'd253);
    for (int i = 0; i < 40; i++) random_pixel();
    drain();

    // Phases over register settings, directed ones first, then random ones.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(16'd65280, 16'd65280, 16'd40960, 16'd40960, 16'd40960, 16'd40960);
        1: write_all(16'd0, 16'd0, 16'd40960, 16'd0, 16'd4096, 16'd40960);
        2: write_all(16'd16320, 16'd48960, 16'd4096, 16'd2048, 16'd4096, 16'd8192);
        default: begin
          lo = 16'($urandom_range(0, 65280));
          hi = 16'($urandom_range(0, 65280));
          if (lo > hi && $urandom_range(0, 3) != 0) {lo, hi} = {hi, lo};
          write_all(lo, hi, 16'($urandom_range(0, 40960)), 16'($urandom_range(0, 40960)),
                    16'($urandom_range(0, 40960)), 16'($urandom_range(0, 40960)));
        end
      endcase
      if (ph == 3) hold_off = 1'b1;
      for (int i = 0; i < 65; i++) begin
        if ($urandom_range(0, 9) == 0) load_entry(8'($urandom), 16'($urandom));
        else random_pixel();
      end
      drain();
    end

    if (mismatches == 0) $display("hsv_gamma_saturation_correct_unit_test passed");
    else $display("hsv_gamma_saturation_correct_unit_test failed");
    $finish;
  end

endmodule

[hsv_gamma_saturation_correct_unit.f]
+incdir+sv
sv/hgsc_pkg.sv
sv/hgsc_front.sv
sv/hgsc_queue.sv
sv/hgsc_back.sv
sv/hsv_gamma_saturation_correct_unit.sv
tb/hsv_gamma_saturation_correct_unit_checker.sv
tb/hsv_gamma_saturation_correct_unit_test.sv
